// ===== sv/integer_to_custom_radix_digits_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix digit converter
// Shared clocked assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_CUSTOM_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_CUSTOM_RADIX_DIGITS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2CRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2CRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/i2crd_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter package
// Shared constants, controller state, command and status types.
// ----------------------------------------------------------------------------
package i2crd_pkg;

    localparam int REG_COUNT  = 8;
    localparam int REG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CHUNK_BITS = 8;

    localparam logic [7:0] SIGN_CHAR  = 8'd45;
    localparam logic [7:0] PLUS_CHAR  = 8'd43;
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

    typedef logic [REG_COUNT-1:0][REG_W-1:0] alpha_regs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START,
        ST_ZERO,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic scan;
        logic div_step;
        logic emit_zero;
        logic emit_sign;
        logic read;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic checked;
        logic scan_end;
        logic radix_ok;
        logic mag_zero;
        logic div_last;
        logic q_zero;
        logic neg;
        logic out_free;
        logic last_digit;
    } status_t;

    // Byte idx of the alphabet; register idx/8, lowest byte first.
    function automatic logic [7:0] alpha_byte(input alpha_regs_t regs,
                                              input logic [5:0] idx);
        return regs[idx[5:3]][{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ===== sv/i2crd_if.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter channels
// Number input channel and character output channel, valid/ready.
// ----------------------------------------------------------------------------
interface i2crd_in_if #(parameter int NUMBER_BITS = 32);
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2crd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ===== sv/i2crd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter controller
// Sequences alphabet check, digit division, sign and digit output.
// ----------------------------------------------------------------------------
module i2crd_ctrl
    import i2crd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    state_next = status.checked ? ST_START : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!status.radix_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.mag_zero)
                begin
                    state_next = ST_ZERO;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_ZERO:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (status.div_last && status.q_zero)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!status.neg || status.out_free)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_digit ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:  cmd.take       = 1'b1;
            ST_SCAN:  cmd.scan       = 1'b1;
            ST_ZERO:  cmd.emit_zero  = status.out_free;
            ST_DIV:   cmd.div_step   = 1'b1;
            ST_SIGN:  cmd.emit_sign  = status.neg && status.out_free;
            ST_READ:  cmd.read       = 1'b1;
            ST_EMIT:  cmd.emit_digit = status.out_free;
            default:  cmd            = '0;
        endcase
    end

endmodule

// ===== sv/i2crd_dp.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter datapath
// Alphabet registers and check, chunked divider, digit stack, output stage.
// ----------------------------------------------------------------------------
module i2crd_dp
    import i2crd_pkg::*;
#(
    parameter int ALPHABET_MAX = 64,
    parameter int NUMBER_BITS  = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  cmd_t                 cmd,
    output status_t              status,
    i2crd_in_if.sink             num,
    i2crd_out_if.source          text
);

    localparam int RADW   = $clog2(ALPHABET_MAX + 1);
    localparam int DIGW   = $clog2(ALPHABET_MAX);
    localparam int CHUNKS = (NUMBER_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int DIVW   = CHUNKS * CHUNK_BITS;
    localparam int CW     = $clog2(CHUNKS + 1);
    localparam int SPW    = $clog2(NUMBER_BITS + 1);
    localparam int SPI    = $clog2(NUMBER_BITS);

    alpha_regs_t            alpha_reg;
    logic                   checked_reg;
    logic [127:0]           seen_reg;
    logic [RADW-1:0]        len_reg;
    logic [RADW-1:0]        radix_reg;
    logic                   radix_ok_reg;
    logic                   neg_reg;
    logic [DIVW-1:0]        d_reg;
    logic [DIVW-1:0]        q_reg;
    logic [RADW-1:0]        rem_reg;
    logic [CW-1:0]          cnt_reg;
    logic [SPW-1:0]         sp_reg;
    logic [DIGW-1:0]        stack_mem [NUMBER_BITS];
    logic [DIGW-1:0]        dig_rd_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_char_reg;
    logic                   out_last_reg;

    logic                   load;
    logic [NUMBER_BITS-1:0] mag;
    logic [7:0]             scan_char;
    logic                   at_lim;
    logic                   scan_bad;
    logic                   scan_end;
    logic [CHUNK_BITS-1:0]  chunk;
    logic [CHUNK_BITS-1:0]  qbits;
    logic [RADW-1:0]        rem_fin;
    logic [RADW:0]          trial;
    logic [DIVW-1:0]        q_fin;
    logic                   div_last;
    logic [SPW-1:0]         sp_dec;
    logic                   out_free;

    assign num.ready = cmd.take;
    assign load      = cmd.take && num.valid;
    assign mag       = num.value[NUMBER_BITS-1] ? NUMBER_BITS'(0 - num.value) : num.value;

    // Alphabet check, one byte per cycle.
    assign scan_char = alpha_byte(alpha_reg, 6'(len_reg));
    assign at_lim    = (len_reg == RADW'(ALPHABET_MAX));
    assign scan_bad  = (scan_char == PLUS_CHAR) || (scan_char == SIGN_CHAR) ||
                       (scan_char < PRINT_LOW) || (scan_char > PRINT_HIGH) ||
                       seen_reg[scan_char[6:0]];
    assign scan_end  = at_lim || (scan_char == 8'd0) || scan_bad;

    // Restoring division of one dividend chunk by the radix.
    assign chunk = d_reg[DIVW-1 -: CHUNK_BITS];
    always_comb
    begin
        rem_fin = rem_reg;
        qbits   = '0;
        trial   = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            trial = {rem_fin, chunk[i]};
            if (trial >= {1'b0, radix_reg})
            begin
                rem_fin  = RADW'(trial - {1'b0, radix_reg});
                qbits[i] = 1'b1;
            end
            else
            begin
                rem_fin = trial[RADW-1:0];
            end
        end
    end
    assign q_fin    = (q_reg << CHUNK_BITS) | DIVW'(qbits);
    assign div_last = (cnt_reg == CW'(CHUNKS - 1));
    assign sp_dec   = sp_reg - 1'b1;
    assign out_free = !out_valid_reg || text.ready;

    // Status to the controller.
    always_comb
    begin
        status.in_valid   = num.valid;
        status.checked    = checked_reg;
        status.scan_end   = scan_end;
        status.radix_ok   = radix_ok_reg;
        status.mag_zero   = (d_reg == '0);
        status.div_last   = div_last;
        status.q_zero     = (q_fin == '0);
        status.neg        = neg_reg;
        status.out_free   = out_free;
        status.last_digit = (sp_reg == SPW'(1));
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= '0;
            checked_reg   <= 1'b0;
            radix_ok_reg  <= 1'b0;
            cnt_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                alpha_reg[cfg_index] <= cfg_data;
                checked_reg          <= 1'b0;
            end
            else if (cmd.scan && scan_end)
            begin
                checked_reg  <= 1'b1;
                radix_ok_reg <= (at_lim || (scan_char == 8'd0)) && (len_reg >= RADW'(2));
            end
            if (load)
            begin
                cnt_reg <= '0;
                sp_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                if (div_last)
                begin
                    cnt_reg <= '0;
                    sp_reg  <= sp_reg + 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else if (cmd.emit_digit)
            begin
                sp_reg <= sp_dec;
            end
            if (cmd.emit_zero || cmd.emit_sign || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= num.value[NUMBER_BITS-1];
            d_reg   <= DIVW'(mag);
            q_reg   <= '0;
            rem_reg <= '0;
            if (!checked_reg)
            begin
                seen_reg <= '0;
                len_reg  <= '0;
            end
        end
        else if (cmd.scan)
        begin
            if (scan_end)
            begin
                radix_reg <= len_reg;
            end
            else
            begin
                seen_reg[scan_char[6:0]] <= 1'b1;
                len_reg                  <= len_reg + 1'b1;
            end
        end
        else if (cmd.div_step)
        begin
            if (div_last)
            begin
                d_reg   <= q_fin;
                q_reg   <= '0;
                rem_reg <= '0;
            end
            else
            begin
                d_reg   <= d_reg << CHUNK_BITS;
                q_reg   <= q_fin;
                rem_reg <= rem_fin;
            end
        end
        if (cmd.emit_zero)
        begin
            out_char_reg <= alpha_byte(alpha_reg, 6'd0);
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit_sign)
        begin
            out_char_reg <= SIGN_CHAR;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_char_reg <= alpha_byte(alpha_reg, 6'(dig_rd_reg));
            out_last_reg <= (sp_reg == SPW'(1));
        end
    end

    // Digit stack: pushed least significant first, popped in reverse.
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && div_last)
        begin
            stack_mem[sp_reg[SPI-1:0]] <= DIGW'(rem_fin);
        end
        if (cmd.read)
        begin
            dig_rd_reg <= stack_mem[sp_dec[SPI-1:0]];
        end
    end

    assign text.valid    = out_valid_reg;
    assign text.out_char = out_char_reg;
    assign text.run_last = out_last_reg;

endmodule

// ===== sv/integer_to_custom_radix_digits.sv =====
// The first number after a configuration write first checks the alphabet, one alphabet
// byte per cycle. Each digit then comes from the 8-bit-per-cycle divider, and each digit
// character is read from the digit stack and then emitted through the output register.
// One number is in work at a time.
// Reset clears the alphabet to zero (invalid) and returns the controller to idle.
// ----------------------------------------------------------------------------
// Radix digit converter top level
// Renders signed numbers as character runs in a configurable alphabet.
// ----------------------------------------------------------------------------
module integer_to_custom_radix_digits
    import i2crd_pkg::*;
#(
    parameter int ALPHABET_MAX = 64,
    parameter int NUMBER_BITS  = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    i2crd_in_if.sink             num,
    i2crd_out_if.source          text
);

    cmd_t    cmd;
    status_t status;

    // Controller.
    i2crd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Datapath.
    i2crd_dp #(
        .ALPHABET_MAX (ALPHABET_MAX),
        .NUMBER_BITS  (NUMBER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .num       (num),
        .text      (text)
    );

endmodule

// ===== sv/i2crd_chk.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`include "integer_to_custom_radix_digits_assert.svh"

module i2crd_chk
    import i2crd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);

    // A stalled output beat stays offered and unchanged.
    `I2CRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped")
    `I2CRD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_char) && $stable(out_last), "stalled beat changed")

    // The sign never ends a run.
    `I2CRD_ASSERT_SAME(a_sign_not_last, out_valid && (out_char == SIGN_CHAR), !out_last, "sign flagged last")

    // One number at a time: after an accepted beat the input closes.
    `I2CRD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input reopened at once")

endmodule

bind integer_to_custom_radix_digits i2crd_chk u_i2crd_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (num.valid),
    .in_ready  (num.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.out_char),
    .out_last  (text.run_last)
);

// ===== test/tb_integer_to_custom_radix_digits.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter testbench
// Drives signed numbers through several alphabets, valid and invalid, and
// checks every character beat against a local predictor, with random idling.
// ----------------------------------------------------------------------------
module tb_integer_to_custom_radix_digits;
    import i2crd_pkg::*;

    // Expected character beat.
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    // Predicts character runs and checks the output stream.
    class char_scoreboard;
        logic [REG_W-1:0] alpha [REG_COUNT];
        char_beat_t       pending [$];
        int               errors;

        function logic [7:0] alpha_char(int idx);
            return alpha[idx / 8][(idx % 8) * 8 +: 8];
        endfunction

        // Radix of the current alphabet, zero when it is invalid.
        function int radix();
            bit seen [256];
            int len;
            logic [7:0] c;
            len = 0;
            while (len < 64)
            begin
                c = alpha_char(len);
                if (c == 8'd0)
                    break;
                if (c == PLUS_CHAR || c == SIGN_CHAR || c < PRINT_LOW || c > PRINT_HIGH
                    || seen[c])
                    return 0;
                seen[c] = 1;
                len++;
            end
            return (len < 2) ? 0 : len;
        endfunction

        function void note_number(logic [31:0] v);
            int         r;
            logic [31:0] mag;
            int         digs [$];
            char_beat_t b;
            r = radix();
            if (r == 0)
                return;
            mag = v[31] ? -v : v;
            if (mag == 0)
            begin
                b.ch = alpha_char(0);
                b.last = 1'b1;
                pending.push_back(b);
                return;
            end
            while (mag != 0)
            begin
                digs.push_front(mag % r);
                mag = mag / r;
            end
            if (v[31])
            begin
                b.ch = SIGN_CHAR;
                b.last = 1'b0;
                pending.push_back(b);
            end
            foreach (digs[i])
            begin
                b.ch = alpha_char(digs[i]);
                b.last = (i == digs.size() - 1);
                pending.push_back(b);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            char_beat_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected beat out_char=%0d run_last=%0d", ch, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ch !== e.ch)
            begin
                $error("out_char: expected %0d, actual %0d", e.ch, ch);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("run_last: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    char_scoreboard       sb;

    i2crd_in_if #(.NUMBER_BITS(32)) num ();
    i2crd_out_if                    text ();

    integer_to_custom_radix_digits i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .num       (num.sink),
        .text      (text.source)
    );

    always #5 clk = ~clk;

    initial
    begin
        num.valid = 1'b0;
        num.value = '0;
        text.ready = 1'b0;
    end

    // Receiver: random stalls, checks each accepted beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text.valid && text.ready)
                sb.check_char(text.out_char, text.run_last);
            text.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Writes one alphabet register while the block is idle; the caller
    // drops the write enable after the last write.
    task automatic write_reg(int idx, logic [REG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= data;
        @(posedge clk);
        if (idx < REG_COUNT)
            sb.alpha[idx] = data;
    endtask

    // Loads an alphabet string; unused registers are cleared.
    task automatic load_alphabet(string s);
        logic [REG_W-1:0] w [REG_COUNT];
        for (int k = 0; k < REG_COUNT; k++)
            w[k] = '0;
        for (int i = 0; i < s.len() && i < 64; i++)
            w[i / 8][(i % 8) * 8 +: 8] = s[i];
        for (int k = 0; k < REG_COUNT; k++)
            write_reg(k, w[k]);
        cfg_we <= 1'b0;
    endtask

    // Sends one number beat with an optional random gap before it. Valid stays
    // high after the accepting edge so that the next beat can follow at once.
    task automatic send_number(logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            num.valid <= 1'b0;
            @(posedge clk);
        end
        num.valid <= 1'b1;
        num.value <= v;
        @(posedge clk);
        while (!num.ready)
            @(posedge clk);
        sb.note_number(v);
    endtask

    // Waits for all characters plus the block's check and division time.
    task automatic drain();
        num.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_number();
        case ($urandom_range(5))
            0: return $urandom_range(20);
            1: return -$urandom_range(20);
            2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
            default: return $urandom;
        endcase
    endfunction

    string printable;
    string bad_alpha;
    string alpha_set [$];

    initial
    begin
        sb = new();
        for (int k = 0; k < REG_COUNT; k++)
            sb.alpha[k] = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset alphabet is invalid: no characters.
        send_number(32'd5);
        send_number(32'h8000_0000);
        drain();

        // Directed extremes in decimal.
        load_alphabet("0123456789");
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hffff_ffff);
        send_number(32'h7fff_ffff);
        send_number(32'h8000_0000);
        send_number(32'd10);
        send_number(32'hffff_fff6);
        send_number(32'd123456789);
        drain();

        // Radix two and a full 64-character alphabet.
        load_alphabet("ab");
        send_number(32'h8000_0000);
        send_number(32'h7fff_ffff);
        send_number(32'd0);
        drain();
        printable = "";
        for (int c = 48; c < 48 + 64; c++)
            printable = {printable, string'(8'(c))};
        load_alphabet(printable);
        send_number(32'h8000_0000);
        send_number(32'hffff_ffff);
        drain();

        // Invalid alphabets: one char, plus, minus, control byte, repeat.
        alpha_set = '{"x", "01+", "0-1", "01\t", "0120"};
        foreach (alpha_set[i])
        begin
            load_alphabet(alpha_set[i]);
            send_number(32'd7);
            send_number(32'hffff_fff0);
            drain();
        end
        // A byte above 126 makes the alphabet invalid.
        bad_alpha = "0123456789abcdef";
        bad_alpha[0] = 8'd127;
        load_alphabet(bad_alpha);
        send_number(32'd9);
        drain();

        // Random phases with different alphabets and idling.
        alpha_set = '{"0123456789abcdef", "01", "XYZ", printable, "0123456789"};
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            load_alphabet(alpha_set[$urandom_range(alpha_set.size() - 1)]);
            for (int n = 0; n < 40; n++)
            begin
                send_number(rand_number());
                // Once per phase, hold off until the stream is empty.
                if (n == 20)
                begin
                    num.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (sb.pending.size() != 0);
                end
            end
            drain();
        end
        // Random raw register contents, mostly invalid.
        for (int k = 0; k < REG_COUNT; k++)
            write_reg(k, {$urandom, $urandom});
        cfg_we <= 1'b0;
        send_number($urandom);
        drain();

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== integer_to_custom_radix_digits.f =====
+incdir+sv
sv/i2crd_pkg.sv
sv/i2crd_if.sv
sv/i2crd_ctrl.sv
sv/i2crd_dp.sv
sv/integer_to_custom_radix_digits.sv
sv/i2crd_chk.sv
test/tb_integer_to_custom_radix_digits.sv
